@@ design/mafl_pkg.sv @@
// Package for the MPEG audio frame length checker.
// Holds the header field codes, the lookup tables as functions and the stage structs.
// No dependencies.
package mafl_pkg;

  // Minimum number of bytes that must be available before a header is considered.
  localparam logic [15:0] HEADER_BYTES = 16'd4;

  // Reciprocal scaling for the constant divisors.
  localparam int RECIP_SHIFT = 26;
  localparam int QUOT_W      = 14;

  // Version index codes (header byte 1, bits 4:3).
  localparam logic [1:0] VI_MPEG25   = 2'd0;
  localparam logic [1:0] VI_RESERVED = 2'd1;
  localparam logic [1:0] VI_MPEG2    = 2'd2;
  localparam logic [1:0] VI_MPEG1    = 2'd3;

  // Layer index codes (header byte 1, bits 2:1).
  localparam logic [1:0] LI_RESERVED = 2'd0;
  localparam logic [1:0] LI_LAYER3   = 2'd1;
  localparam logic [1:0] LI_LAYER2   = 2'd2;
  localparam logic [1:0] LI_LAYER1   = 2'd3;

  // Sample-rate index codes (header byte 2, bits 3:2).
  localparam logic [1:0] SI_RATE0    = 2'd0;
  localparam logic [1:0] SI_RATE1    = 2'd1;
  localparam logic [1:0] SI_RATE2    = 2'd2;
  localparam logic [1:0] SI_RESERVED = 2'd3;

  // Bitrate index codes that never give a usable frame.
  localparam logic [3:0] BI_FREE = 4'd0;
  localparam logic [3:0] BI_BAD  = 4'd15;

  // Output version codes.
  localparam logic [1:0] VC_NONE   = 2'd0;
  localparam logic [1:0] VC_MPEG1  = 2'd1;
  localparam logic [1:0] VC_MPEG2  = 2'd2;
  localparam logic [1:0] VC_MPEG25 = 2'd3;

  // Bitrates in kbit/s by bitrate index.
  localparam logic [8:0] BR_M1_L1 [16] = '{
    9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
    9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
  localparam logic [8:0] BR_M1_L2 [16] = '{
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
  localparam logic [8:0] BR_M1_L3 [16] = '{
    9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
    9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
  localparam logic [8:0] BR_M2_L1 [16] = '{
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
  localparam logic [8:0] BR_M2_L23 [16] = '{
    9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
    9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

  // Samples per frame divided by eight, times 1000.
  localparam logic [17:0] SPF_K_1152 = 18'd144000;
  localparam logic [17:0] SPF_K_576  = 18'd72000;
  localparam logic [17:0] SPF_K_384  = 18'd48000;

  // Operands for the size division.
  typedef struct packed {
    logic [17:0] spf_k;
    logic [8:0]  kbps;
    logic [1:0]  shift;
    logic [1:0]  sr_idx;
  } div_op_t;

  // Data that travels alongside the division.
  typedef struct packed {
    logic        ok;
    logic [2:0]  slot;
    logic [1:0]  version_code;
    logic [1:0]  layer_number;
    logic [15:0] avail;
  } side_t;

  function automatic logic [8:0] kbps_lookup(input logic [1:0] vi, input logic [1:0] li,
                                             input logic [3:0] bi);
    logic [8:0] kbps;
    kbps = '0;
    if (vi == VI_MPEG1) begin
      case (li)
        LI_LAYER1: kbps = BR_M1_L1[bi];
        LI_LAYER2: kbps = BR_M1_L2[bi];
        LI_LAYER3: kbps = BR_M1_L3[bi];
        default:   kbps = '0;
      endcase
    end else if (vi == VI_MPEG2 || vi == VI_MPEG25) begin
      case (li)
        LI_LAYER1: kbps = BR_M2_L1[bi];
        LI_LAYER2: kbps = BR_M2_L23[bi];
        LI_LAYER3: kbps = BR_M2_L23[bi];
        default:   kbps = '0;
      endcase
    end
    return kbps;
  endfunction

  function automatic logic [17:0] spf_k_lookup(input logic [1:0] vi, input logic [1:0] li);
    logic [17:0] spf_k;
    case (li)
      LI_LAYER1: spf_k = SPF_K_384;
      LI_LAYER2: spf_k = SPF_K_1152;
      LI_LAYER3: spf_k = (vi == VI_MPEG1) ? SPF_K_1152 : SPF_K_576;
      default:   spf_k = '0;
    endcase
    return spf_k;
  endfunction

  // Each version's sample rates are the MPEG-2.5 rates scaled by a power of two.
  function automatic logic [1:0] rate_shift(input logic [1:0] vi);
    logic [1:0] shift;
    case (vi)
      VI_MPEG1: shift = 2'd2;
      VI_MPEG2: shift = 2'd1;
      default:  shift = 2'd0;
    endcase
    return shift;
  endfunction

  function automatic logic [QUOT_W-1:0] rate_divisor(input logic [1:0] si);
    logic [QUOT_W-1:0] d;
    case (si)
      SI_RATE0: d = QUOT_W'(11025);
      SI_RATE1: d = QUOT_W'(12000);
      default:  d = QUOT_W'(8000);
    endcase
    return d;
  endfunction

  // floor(2**RECIP_SHIFT / divisor)
  function automatic logic [QUOT_W-1:0] rate_recip(input logic [1:0] si);
    logic [QUOT_W-1:0] m;
    case (si)
      SI_RATE0: m = QUOT_W'(6086);
      SI_RATE1: m = QUOT_W'(5592);
      default:  m = QUOT_W'(8388);
    endcase
    return m;
  endfunction

  function automatic logic [1:0] version_of(input logic [1:0] vi);
    logic [1:0] vc;
    case (vi)
      VI_MPEG1:  vc = VC_MPEG1;
      VI_MPEG2:  vc = VC_MPEG2;
      VI_MPEG25: vc = VC_MPEG25;
      default:   vc = VC_NONE;
    endcase
    return vc;
  endfunction

endpackage

@@ design/mpeg_audio_frame_length.sv @@
// MPEG audio frame length checker, top level.
// Stages: input register, divider stages, output register. Throughput: one request
// per cycle while out_ready keeps up; each stage holds its item only while the stage
// after it is full and stalled, so bubbles are filled and nothing is lost or repeated.
// The critical stage is the 26 x 14 reciprocal multiply in mafl_div.
// Reset clears the stage valid bits only; data registers are not reset.
module mpeg_audio_frame_length import mafl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  header_byte0,
  input  logic [7:0]  header_byte1,
  input  logic [7:0]  header_byte2,
  input  logic [15:0] available_len,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_frame,
  output logic [11:0] frame_bytes,
  output logic [1:0]  version_code,
  output logic [1:0]  layer_number
);

  div_op_t           dec_op;
  side_t             dec_side;
  div_op_t           op1;
  side_t             side1;
  side_t             side4;
  logic [QUOT_W-1:0] quot;
  logic [11:0]       size_next;
  logic              fits;

  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  // A stage may load when it is empty or its item moves on in the same cycle.
  assign en5      = !v5 || out_ready;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;
  assign out_valid = v5;

  mafl_decode u_decode (
    .header_byte0  (header_byte0),
    .header_byte1  (header_byte1),
    .header_byte2  (header_byte2),
    .available_len (available_len),
    .op            (dec_op),
    .side          (dec_side)
  );

  always_ff @(posedge clk) begin
    if (en1) begin
      op1   <= dec_op;
      side1 <= dec_side;
    end
  end

  mafl_div u_div (
    .clk      (clk),
    .en       ({en4, en3, en2}),
    .op       (op1),
    .side_in  (side1),
    .quot     (quot),
    .side_out (side4)
  );

  assign size_next = quot[11:0] + {9'd0, side4.slot};
  assign fits      = side4.ok && (side4.avail >= {4'd0, size_next});

  always_ff @(posedge clk) begin
    if (en5) begin
      is_frame     <= fits;
      frame_bytes  <= fits ? size_next : 12'd0;
      version_code <= fits ? side4.version_code : VC_NONE;
      layer_number <= fits ? side4.layer_number : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

endmodule

@@ design/mafl_decode.sv @@
// Header decoder: sync check, field extraction and table lookups.
// Depends on mafl_pkg for the field codes and tables.
module mafl_decode import mafl_pkg::*; (
  input  logic [7:0]  header_byte0,
  input  logic [7:0]  header_byte1,
  input  logic [7:0]  header_byte2,
  input  logic [15:0] available_len,
  output div_op_t     op,
  output side_t       side
);

  logic [1:0] vi;
  logic [1:0] li;
  logic [3:0] bi;
  logic [1:0] si;
  logic       pad;
  logic       sync_ok;
  logic       fields_ok;

  assign vi  = header_byte1[4:3];
  assign li  = header_byte1[2:1];
  assign bi  = header_byte2[7:4];
  assign si  = header_byte2[3:2];
  assign pad = header_byte2[1];

  assign sync_ok   = (header_byte0 == 8'hFF) && (header_byte1[7:5] == 3'b111);
  // Reserved version, layer or rate codes and the free or forbidden bitrate are all rejected.
  assign fields_ok = (vi != VI_RESERVED) && (li != LI_RESERVED) && (si != SI_RESERVED) &&
                     (bi != BI_FREE) && (bi != BI_BAD);

  always_comb begin
    op.spf_k  = spf_k_lookup(vi, li);
    op.kbps   = kbps_lookup(vi, li, bi);
    op.shift  = rate_shift(vi);
    op.sr_idx = si;

    side.ok           = sync_ok && fields_ok && (available_len >= HEADER_BYTES);
    side.slot         = pad ? ((li == LI_LAYER1) ? 3'd4 : 3'd1) : 3'd0;
    side.version_code = version_of(vi);
    side.layer_number = 2'd0 - li;
    side.avail        = available_len;
  end

endmodule

@@ design/mafl_div.sv @@
// Three-stage divider of samples times bitrate by the sample rate, using a reciprocal
// multiply and one correction step. Depends on mafl_pkg for the constant tables.
module mafl_div import mafl_pkg::*; (
  input  logic              clk,
  input  logic [2:0]        en,
  input  div_op_t           op,
  input  side_t             side_in,
  output logic [QUOT_W-1:0] quot,
  output side_t             side_out
);

  // Stage 2: numerator, already divided by the power-of-two part of the rate.
  logic [26:0]              num_full;
  logic [25:0]              n2;
  logic [1:0]               sr2;
  side_t                    side2;

  // Stage 3: quotient estimate, at most one below the true quotient.
  logic [25+QUOT_W:0]       prod_recip;
  logic [QUOT_W-1:0]        qe3;
  logic [25:0]              n3;
  logic [1:0]               sr3;
  side_t                    side3;

  // Stage 4: remainder of the estimate, below twice the divisor.
  logic [2*QUOT_W-1:0]      prod_back;
  logic [25:0]              diff;
  logic [QUOT_W-1:0]        qe4;
  logic [QUOT_W:0]          rem4;
  logic [1:0]               sr4;

  assign num_full   = op.spf_k * op.kbps;
  assign prod_recip = n2 * rate_recip(sr2);
  assign prod_back  = qe3 * rate_divisor(sr3);
  assign diff       = n3 - prod_back[25:0];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      n2    <= num_full[25:0] >> op.shift;
      sr2   <= op.sr_idx;
      side2 <= side_in;
    end
    if (en[1]) begin
      qe3   <= prod_recip[RECIP_SHIFT +: QUOT_W];
      n3    <= n2;
      sr3   <= sr2;
      side3 <= side2;
    end
    if (en[2]) begin
      qe4      <= qe3;
      rem4     <= diff[QUOT_W:0];
      sr4      <= sr3;
      side_out <= side3;
    end
  end

  assign quot = qe4 + QUOT_W'(rem4 >= {1'b0, rate_divisor(sr4)});

endmodule

@@ sim/tb_mpeg_audio_frame_length.sv @@
`timescale 1ns / 100ps
// Testbench for mpeg_audio_frame_length: directed header cases, then random headers.
// Every result is checked against an in-bench prediction of the frame size.
// Depends on mafl_pkg and the mpeg_audio_frame_length top level.
module tb_mpeg_audio_frame_length;
  import mafl_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic        is_frame;
    logic [11:0] frame_bytes;
    logic [1:0]  version_code;
    logic [1:0]  layer_number;
  } frame_info_t;

  // Bitrates in kbit/s: [0] MPEG-1, [1] MPEG-2 and MPEG-2.5; then layer 1, 2, 3.
  localparam int KBPS_TABLE [2][3][16] = '{
    '{
      '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
      '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
      '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0}
    },
    '{
      '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
      '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
      '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}
    }
  };

  // Sample rates in Hz, indexed by version index and then sample-rate index.
  localparam int RATE_HZ [4][4] = '{
    '{11025, 12000, 8000, 0},
    '{0, 0, 0, 0},
    '{22050, 24000, 16000, 0},
    '{44100, 48000, 32000, 0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  header_byte0 = '0;
  logic [7:0]  header_byte1 = '0;
  logic [7:0]  header_byte2 = '0;
  logic [15:0] available_len = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        is_frame;
  logic [11:0] frame_bytes;
  logic [1:0]  version_code;
  logic [1:0]  layer_number;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count = 0;
  int cycle_count = 0;
  frame_info_t pending_frames [$];

  mpeg_audio_frame_length uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .header_byte0 (header_byte0),
    .header_byte1 (header_byte1),
    .header_byte2 (header_byte2),
    .available_len(available_len),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .is_frame     (is_frame),
    .frame_bytes  (frame_bytes),
    .version_code (version_code),
    .layer_number (layer_number)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic frame_info_t predict_frame(input logic [7:0] b0, input logic [7:0] b1,
                                                input logic [7:0] b2, input logic [15:0] avail);
    frame_info_t info;
    logic [1:0]  vi;
    logic [1:0]  li;
    int          family;
    int          layer;
    int          kbps;
    int          hz;
    int          samples;
    int          size;
    info = '0;
    vi = b1[4:3];
    li = b1[2:1];
    if (avail < HEADER_BYTES || b0 != 8'hFF || b1[7:5] != 3'b111) return info;
    if (vi == VI_RESERVED || li == LI_RESERVED) return info;
    family = (vi == VI_MPEG1) ? 0 : 1;
    layer = 4 - int'(li);
    kbps = KBPS_TABLE[family][layer - 1][b2[7:4]];
    hz = RATE_HZ[vi][b2[3:2]];
    case (li)
      LI_LAYER1: samples = 384;
      LI_LAYER2: samples = 1152;
      default:   samples = (vi == VI_MPEG1) ? 1152 : 576;
    endcase
    if (kbps == 0 || hz == 0) return info;
    size = ((samples / 8) * (kbps * 1000)) / hz;
    // A padding slot is four bytes in layer 1 and one byte otherwise.
    if (b2[1]) size += (li == LI_LAYER1) ? 4 : 1;
    if (int'(avail) < size) return info;
    info.is_frame = 1'b1;
    info.frame_bytes = 12'(size);
    case (vi)
      VI_MPEG1: info.version_code = VC_MPEG1;
      VI_MPEG2: info.version_code = VC_MPEG2;
      default:  info.version_code = VC_MPEG25;
    endcase
    info.layer_number = 2'(layer);
    return info;
  endfunction

  // Byte 1 with the sync bits set; bit 0 is the protection bit.
  function automatic logic [7:0] sync_byte1(input logic [1:0] vi, input logic [1:0] li,
                                            input logic prot);
    return {3'b111, vi, li, prot};
  endfunction

  task automatic send_request(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [15:0] avail);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    header_byte0 <= b0;
    header_byte1 <= b1;
    header_byte2 <= b2;
    available_len <= avail;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
  endtask

  // Receiver side: stall at random according to the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("mpeg_audio_frame_length verification failed");
      $finish;
    end
  end

  // Predictions are queued on acceptance and compared on each delivered result.
  always @(posedge clk) begin : check_results
    frame_info_t want;
    if (!rst) begin
      if (in_valid && in_ready)
        pending_frames.push_back(predict_frame(header_byte0, header_byte1, header_byte2,
                                               available_len));
      if (out_valid && out_ready) begin
        if (pending_frames.size() == 0) begin
          $error("result delivered with no request outstanding");
          error_count++;
        end else begin
          want = pending_frames.pop_front();
          if (is_frame !== want.is_frame) begin
            $error("is_frame: expected %0d, got %0d", want.is_frame, is_frame);
            error_count++;
          end
          if (frame_bytes !== want.frame_bytes) begin
            $error("frame_bytes: expected %0d, got %0d", want.frame_bytes, frame_bytes);
            error_count++;
          end
          if (version_code !== want.version_code) begin
            $error("version_code: expected %0d, got %0d", want.version_code, version_code);
            error_count++;
          end
          if (layer_number !== want.layer_number) begin
            $error("layer_number: expected %0d, got %0d", want.layer_number, layer_number);
            error_count++;
          end
        end
      end
    end
  end

  // MPEG-1 layer 3 at 128 kbit/s and 44.1 kHz is 417 bytes.
  task automatic test_short_buffer();
    logic [7:0] b1;
    b1 = sync_byte1(VI_MPEG1, LI_LAYER3, 1'b1);
    send_request(8'hFF, b1, {4'd9, SI_RATE0, 2'b00}, 16'd0);
    send_request(8'hFF, b1, {4'd9, SI_RATE0, 2'b00}, 16'd3);
    send_request(8'hFF, b1, {4'd9, SI_RATE0, 2'b00}, 16'd4);
    send_request(8'hFF, b1, {4'd9, SI_RATE0, 2'b00}, 16'd416);
    send_request(8'hFF, b1, {4'd9, SI_RATE0, 2'b00}, 16'd417);
  endtask

  // The longest frame: MPEG-2.5 layer 2 at 160 kbit/s, 8 kHz, padded, 2881 bytes.
  task automatic test_frame_exceeds_buffer();
    logic [7:0] b1;
    logic [7:0] b2;
    b1 = sync_byte1(VI_MPEG25, LI_LAYER2, 1'b0);
    b2 = {4'd14, SI_RATE2, 2'b11};
    send_request(8'hFF, b1, b2, 16'd2880);
    send_request(8'hFF, b1, b2, 16'd2881);
    send_request(8'hFF, b1, b2, 16'hFFFF);
  endtask

  task automatic test_bad_sync();
    send_request(8'h7F, sync_byte1(VI_MPEG1, LI_LAYER3, 1'b1), 8'h90, 16'hFFFF);
    send_request(8'hFF, 8'hDB, 8'h90, 16'hFFFF);
    send_request(8'h00, 8'h00, 8'h00, 16'h0000);
  endtask

  task automatic test_reserved_codes();
    send_request(8'hFF, sync_byte1(VI_RESERVED, LI_LAYER3, 1'b1), 8'h90, 16'hFFFF);
    send_request(8'hFF, sync_byte1(VI_MPEG1, LI_RESERVED, 1'b1), 8'h90, 16'hFFFF);
    send_request(8'hFF, sync_byte1(VI_MPEG1, LI_LAYER2, 1'b1),
                 {BI_FREE, SI_RATE1, 2'b10}, 16'hFFFF);
    send_request(8'hFF, sync_byte1(VI_MPEG2, LI_LAYER1, 1'b0),
                 {BI_BAD, SI_RATE0, 2'b00}, 16'hFFFF);
    send_request(8'hFF, sync_byte1(VI_MPEG1, LI_LAYER1, 1'b1),
                 {4'd5, SI_RESERVED, 2'b01}, 16'hFFFF);
    send_request(8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
  endtask

  // Every version with every layer, alternating lowest and highest bitrate.
  task automatic test_each_version_layer();
    logic [1:0] versions [3];
    logic [1:0] layers [3];
    logic [1:0] si;
    logic [3:0] bi;
    versions = '{VI_MPEG25, VI_MPEG2, VI_MPEG1};
    layers = '{LI_LAYER1, LI_LAYER2, LI_LAYER3};
    foreach (versions[v]) begin
      foreach (layers[l]) begin
        bi = ((v + l) % 2 == 0) ? 4'd1 : 4'd14;
        si = 2'((v + l) % 3);
        send_request(8'hFF, sync_byte1(versions[v], layers[l], 1'($urandom)),
                     {bi, si, 1'(l % 2), 1'b0}, 16'hFFFF);
      end
    end
  endtask

  task automatic test_random_headers(input int count);
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [15:0] avail;
    logic [1:0]  vi;
    frame_info_t unlimited;
    int          mode;
    int          pick;
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(99);
      b0 = 8'hFF;
      b2 = 8'($urandom);
      if (mode < 12) begin
        b0 = 8'($urandom);
        b1 = 8'($urandom);
      end else if (mode < 20) begin
        // Near misses on the sync pattern.
        b1 = {3'($urandom_range(6)), 5'($urandom)};
        if ($urandom_range(1)) begin
          b0 = 8'($urandom);
          b1 = 8'hE0 | 8'($urandom);
        end
      end else if (mode < 35) begin
        b1 = 8'hE0 | 8'($urandom);
      end else begin
        case ($urandom_range(2))
          0:       vi = VI_MPEG25;
          1:       vi = VI_MPEG2;
          default: vi = VI_MPEG1;
        endcase
        b1 = sync_byte1(vi, 2'($urandom_range(1, 3)), 1'($urandom));
        b2 = {4'($urandom_range(1, 14)), 2'($urandom_range(2)), 2'($urandom)};
      end
      unlimited = predict_frame(b0, b1, b2, 16'hFFFF);
      pick = $urandom_range(9);
      if (unlimited.is_frame && pick < 5)
        avail = 16'(unlimited.frame_bytes) - 16'd1 + 16'($urandom_range(2));
      else if (pick < 7)
        avail = 16'($urandom_range(7));
      else if (pick < 8)
        avail = 16'($urandom);
      else
        avail = 16'($urandom_range(3000));
      send_request(b0, b1, b2, avail);
    end
  endtask

  initial begin
    send_idle_pct <= 19;
    recv_idle_pct <= 71;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_short_buffer();
    test_frame_exceeds_buffer();
    test_bad_sync();
    test_reserved_codes();
    test_each_version_layer();
    test_random_headers(280);
    wait_for_results();

    send_idle_pct <= 71;
    recv_idle_pct <= 19;
    @(posedge clk);
    test_random_headers(285);
    wait_for_results();

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    @(posedge clk);
    test_random_headers(285);
    wait_for_results();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("mpeg_audio_frame_length verification clean");
    else
      $display("mpeg_audio_frame_length verification failed");
    $finish;
  end

endmodule

@@ mpeg_audio_frame_length.f @@
design/mafl_pkg.sv
design/mafl_decode.sv
design/mafl_div.sv
design/mpeg_audio_frame_length.sv
sim/tb_mpeg_audio_frame_length.sv
